// ----- hdl/wsfd_pkg.sv -----
// Package for the WebSocket frame deframer: length codes, bit positions and field widths.
// Has no dependencies; used by websocket_frame_deframer_core.
`default_nettype none

package wsfd_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned OpcW    = 4;
	localparam int unsigned LenW    = 32;
	localparam int unsigned LcodeW  = 7;
	localparam int unsigned HcntW   = 4;

	// Length codes in the second header byte that announce an extended length.
	localparam logic [LcodeW-1:0] LEN16_CODE = 7'h7E;
	localparam logic [LcodeW-1:0] LEN64_CODE = 7'h7F;

	// Number of bytes in each optional header part.
	localparam logic [HcntW-1:0] LEN16_BYTES = 4'd2;
	localparam logic [HcntW-1:0] LEN64_BYTES = 4'd8;
	localparam logic [HcntW-1:0] KEY_BYTES   = 4'd4;

	// Result kinds.
	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

endpackage

`default_nettype wire

// ----- hdl/websocket_frame_deframer_core.sv -----
// WebSocket frame deframer: parses a byte stream into header and payload words.
// Depends on wsfd_pkg for length codes and widths.
//
//   channel | direction | fields
//   --------+-----------+-----------------------------------------------------------
//   in      | sink      | rx_byte
//   out     | source    | kind, opcode, fin_bit, mask_bit, payload_length,
//           |           | data_byte, last
//
// One byte is taken per cycle while no result is stalled: a byte is registered in the input
// register, parsed from there, and its result (if any) lands in the output register, which
// offers the word to the receiver through out_valid and the output fields.
// Throughput is one byte per cycle, set by the single parse stage, unless the output stalls.
// Reset (arst_n low) returns the parser to "first header byte expected" with no word held.
// When the output register is full and not taken, a byte that would make a result waits
// in the input register; header bytes that give no result still move on.
`default_nettype none

module websocket_frame_deframer_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [wsfd_pkg::ByteW-1:0]      rx_byte,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 kind,
	output logic [wsfd_pkg::OpcW-1:0]            opcode,
	output logic                                 fin_bit,
	output logic                                 mask_bit,
	output logic [wsfd_pkg::LenW-1:0]            payload_length,
	output logic [wsfd_pkg::ByteW-1:0]           data_byte,
	output logic                                 last
);

	typedef enum logic [2:0] {
		PH_FIRST,
		PH_SECOND,
		PH_EXTLEN,
		PH_KEY,
		PH_DATA
	} phase_t;

	// Input register
	logic                          v_s1;
	logic [wsfd_pkg::ByteW-1:0]    byte_s1;

	// Parser state
	phase_t                        phase_q;
	logic [wsfd_pkg::HcntW-1:0]    hcnt_q;
	logic                          len64_q;
	logic [wsfd_pkg::LenW-1:0]     len_q;
	logic                          ovf_q;
	logic [wsfd_pkg::LenW-1:0]     remain_q;
	logic [wsfd_pkg::OpcW-1:0]     opc_q;
	logic                          fin_q;
	logic                          masked_q;

	// Output register
	logic                          ov_q;
	logic                          kind_q;
	logic [wsfd_pkg::OpcW-1:0]     opcode_q;
	logic                          final_q;
	logic                          masked_out_q;
	logic [wsfd_pkg::LenW-1:0]     plen_q;
	logic [wsfd_pkg::ByteW-1:0]    data_q;
	logic                          last_q;

	// Next-state values
	phase_t                        n_phase;
	logic [wsfd_pkg::HcntW-1:0]    n_hcnt;
	logic                          n_len64;
	logic [wsfd_pkg::LenW-1:0]     n_len;
	logic                          n_ovf;
	logic [wsfd_pkg::LenW-1:0]     n_remain;
	logic [wsfd_pkg::OpcW-1:0]     n_opc;
	logic                          n_fin;
	logic                          n_masked;
	logic                          produce;
	logic                          finish;
	logic                          r_kind;
	logic [wsfd_pkg::ByteW-1:0]    r_data;
	logic                          r_last;
	logic [wsfd_pkg::LenW-1:0]     sat_len;
	logic [wsfd_pkg::HcntW-1:0]    cnt_inc;
	logic [wsfd_pkg::LcodeW-1:0]   lcode;
	logic                          advance;

	always_comb begin
		n_phase  = phase_q;
		n_hcnt   = hcnt_q;
		n_len64  = len64_q;
		n_len    = len_q;
		n_ovf    = ovf_q;
		n_remain = remain_q;
		n_opc    = opc_q;
		n_fin    = fin_q;
		n_masked = masked_q;
		produce  = 1'b0;
		finish   = 1'b0;
		r_kind   = wsfd_pkg::KIND_HEADER;
		r_data   = '0;
		r_last   = 1'b0;
		cnt_inc  = hcnt_q + 4'd1;
		lcode    = byte_s1[wsfd_pkg::LcodeW-1:0];
		case (phase_q)
			PH_SECOND: begin
				n_masked = byte_s1[7];
				n_hcnt   = '0;
				n_ovf    = 1'b0;
				if (lcode == wsfd_pkg::LEN16_CODE || lcode == wsfd_pkg::LEN64_CODE) begin
					n_len64 = (lcode == wsfd_pkg::LEN64_CODE);
					n_len   = '0;
					n_phase = PH_EXTLEN;
				end else begin
					n_len = {{(wsfd_pkg::LenW-wsfd_pkg::LcodeW){1'b0}}, lcode};
					if (byte_s1[7]) begin
						n_phase = PH_KEY;
					end else begin
						finish = 1'b1;
					end
				end
			end
			PH_EXTLEN: begin
				// Anything shifted out of the top byte saturates the length.
				n_len  = {len_q[wsfd_pkg::LenW-9:0], byte_s1};
				n_ovf  = ovf_q | (len_q[wsfd_pkg::LenW-1 -: 8] != 8'd0);
				n_hcnt = cnt_inc;
				if (cnt_inc >= (len64_q ? wsfd_pkg::LEN64_BYTES : wsfd_pkg::LEN16_BYTES)) begin
					n_hcnt = '0;
					if (masked_q) begin
						n_phase = PH_KEY;
					end else begin
						finish = 1'b1;
					end
				end
			end
			PH_KEY: begin
				n_hcnt = cnt_inc;
				if (cnt_inc >= wsfd_pkg::KEY_BYTES) begin
					finish = 1'b1;
				end
			end
			PH_DATA: begin
				n_remain = remain_q - 32'd1;
				produce  = 1'b1;
				r_kind   = wsfd_pkg::KIND_PAYLOAD;
				r_data   = byte_s1;
				r_last   = (n_remain == '0);
				if (n_remain == '0) begin
					n_phase = PH_FIRST;
				end
			end
			default: begin
				n_fin    = byte_s1[7];
				n_opc    = byte_s1[wsfd_pkg::OpcW-1:0];
				n_hcnt   = '0;
				n_len64  = 1'b0;
				n_len    = '0;
				n_ovf    = 1'b0;
				n_remain = '0;
				n_masked = 1'b0;
				n_phase  = PH_SECOND;
			end
		endcase

		sat_len = n_ovf ? '1 : n_len;
		if (finish) begin
			n_len    = sat_len;
			n_ovf    = 1'b0;
			n_remain = sat_len;
			n_hcnt   = '0;
			produce  = 1'b1;
			r_kind   = wsfd_pkg::KIND_HEADER;
			r_last   = (sat_len == '0);
			n_phase  = (sat_len == '0) ? PH_FIRST : PH_DATA;
		end
	end

	// A byte with no result may move on even while the output word is stalled.
	assign advance  = v_s1 && (!produce || !ov_q || out_ready);
	assign in_ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			phase_q  <= PH_FIRST;
			hcnt_q   <= '0;
			len64_q  <= 1'b0;
			len_q    <= '0;
			ovf_q    <= 1'b0;
			remain_q <= '0;
			opc_q    <= '0;
			fin_q    <= 1'b0;
			masked_q <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (advance) begin
				phase_q  <= n_phase;
				hcnt_q   <= n_hcnt;
				len64_q  <= n_len64;
				len_q    <= n_len;
				ovf_q    <= n_ovf;
				remain_q <= n_remain;
				opc_q    <= n_opc;
				fin_q    <= n_fin;
				masked_q <= n_masked;
			end
			if (advance && produce) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
		if (advance && produce) begin
			kind_q       <= r_kind;
			opcode_q     <= n_opc;
			final_q      <= n_fin;
			masked_out_q <= n_masked;
			plen_q       <= n_len;
			data_q       <= r_data;
			last_q       <= r_last;
		end
	end

	assign out_valid      = ov_q;
	assign kind           = kind_q;
	assign opcode         = opcode_q;
	assign fin_bit        = final_q;
	assign mask_bit       = masked_out_q;
	assign payload_length = plen_q;
	assign data_byte      = data_q;
	assign last           = last_q;

	// While payload is expected at least one byte must still be owed.
	a_data_remain: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (remain_q != '0))
		else $error("payload phase with no bytes remaining");

	// Header byte count never passes the longest extended length.
	a_hcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		hcnt_q < wsfd_pkg::LEN64_BYTES)
		else $error("header byte count out of range");

	// Saturation is pending only while a 64-bit length is being assembled or its key skipped.
	a_ovf_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> ((phase_q == PH_EXTLEN || phase_q == PH_KEY) && len64_q))
		else $error("length overflow flag outside a 64-bit length");

	// A payload word always carries the frame's nonzero length.
	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && produce && r_kind == wsfd_pkg::KIND_PAYLOAD) |=>
			(plen_q != '0 && kind_q == wsfd_pkg::KIND_PAYLOAD))
		else $error("payload word with zero length");

endmodule

`default_nettype wire

// ----- test/websocket_frame_deframer_core_tb.sv -----
// Self-checking testbench for websocket_frame_deframer_core: directed table rows, random well-formed
// frames, then tail rows; each output word is checked against the table or a behavioural parser.
// Depends on wsfd_pkg and the RTL of the core only.
module websocket_frame_deframer_core_tb;

	typedef enum logic [2:0] {PH_FIRST, PH_SECOND, PH_EXTLEN, PH_KEY, PH_DATA} parse_phase_t;

	typedef struct packed {
		logic                        kind;
		logic [wsfd_pkg::OpcW-1:0]   opcode;
		logic                        fin_bit;
		logic                        mask_bit;
		logic [wsfd_pkg::LenW-1:0]   payload_length;
		logic [wsfd_pkg::ByteW-1:0]  data_byte;
		logic                        last;
	} deframe_word_t;

	typedef struct packed {
		logic [wsfd_pkg::ByteW-1:0]  rx;
		bit                          typed;
		bit                          has_word;
		deframe_word_t               w;
	} stim_row_t;

	localparam deframe_word_t NO_WORD = '0;
	localparam logic HDR = wsfd_pkg::KIND_HEADER;
	localparam logic PAY = wsfd_pkg::KIND_PAYLOAD;
	localparam int N_ROWS      = 33;
	localparam int TAIL_START  = 21;
	localparam int RAND_ITEMS  = 410;
	localparam int STALL_LIMIT = 1000;

	// Rows from TAIL_START on carry a saturated 64-bit length, which leaves the parser in the
	// payload phase for the rest of the run, so they are played after the random part.
	stim_row_t dir_rows [0:N_ROWS-1] = '{
		//  byte   typed word   kind  opc   fin   msk   length          data   last
		'{8'h89, 1'b1, 1'b0, NO_WORD},
		'{8'h00, 1'b1, 1'b1, '{HDR, 4'h9, 1'b1, 1'b0, 32'd0,         8'h00, 1'b1}},
		'{8'h70, 1'b1, 1'b0, NO_WORD},
		'{8'h02, 1'b1, 1'b1, '{HDR, 4'h0, 1'b0, 1'b0, 32'd2,         8'h00, 1'b0}},
		'{8'hFF, 1'b1, 1'b1, '{PAY, 4'h0, 1'b0, 1'b0, 32'd2,         8'hFF, 1'b0}},
		'{8'h00, 1'b1, 1'b1, '{PAY, 4'h0, 1'b0, 1'b0, 32'd2,         8'h00, 1'b1}},
		'{8'h8F, 1'b1, 1'b0, NO_WORD},
		'{8'hFE, 1'b1, 1'b0, NO_WORD},
		'{8'h00, 1'b1, 1'b0, NO_WORD},
		'{8'h00, 1'b1, 1'b0, NO_WORD},
		'{8'hA5, 1'b1, 1'b0, NO_WORD},
		'{8'h5A, 1'b1, 1'b0, NO_WORD},
		'{8'hFF, 1'b1, 1'b0, NO_WORD},
		'{8'h00, 1'b1, 1'b1, '{HDR, 4'hF, 1'b1, 1'b1, 32'd0,         8'h00, 1'b1}},
		'{8'h4A, 1'b0, 1'b0, NO_WORD},
		'{8'h7E, 1'b0, 1'b0, NO_WORD},
		'{8'h00, 1'b0, 1'b0, NO_WORD},
		'{8'h03, 1'b0, 1'b0, NO_WORD},
		'{8'h11, 1'b0, 1'b0, NO_WORD},
		'{8'h22, 1'b0, 1'b0, NO_WORD},
		'{8'h33, 1'b0, 1'b0, NO_WORD},
		'{8'h81, 1'b1, 1'b0, NO_WORD},
		'{8'h7F, 1'b1, 1'b0, NO_WORD},
		'{8'h80, 1'b1, 1'b0, NO_WORD},
		'{8'h00, 1'b1, 1'b0, NO_WORD},
		'{8'h00, 1'b1, 1'b0, NO_WORD},
		'{8'h00, 1'b1, 1'b0, NO_WORD},
		'{8'h00, 1'b1, 1'b0, NO_WORD},
		'{8'h00, 1'b1, 1'b0, NO_WORD},
		'{8'h00, 1'b1, 1'b0, NO_WORD},
		'{8'h00, 1'b1, 1'b1, '{HDR, 4'h1, 1'b1, 1'b0, 32'hFFFF_FFFF, 8'h00, 1'b0}},
		'{8'hC3, 1'b1, 1'b1, '{PAY, 4'h1, 1'b1, 1'b0, 32'hFFFF_FFFF, 8'hC3, 1'b0}},
		'{8'h3C, 1'b1, 1'b1, '{PAY, 4'h1, 1'b1, 1'b0, 32'hFFFF_FFFF, 8'h3C, 1'b0}}
	};

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic [wsfd_pkg::ByteW-1:0]    rx_byte;
	logic                          out_valid;
	logic                          out_ready;
	logic                          kind;
	logic [wsfd_pkg::OpcW-1:0]     opcode;
	logic                          fin_bit;
	logic                          mask_bit;
	logic [wsfd_pkg::LenW-1:0]     payload_length;
	logic [wsfd_pkg::ByteW-1:0]    data_byte;
	logic                          last;

	// Parser state of the predictor.
	parse_phase_t                  ph = PH_FIRST;
	logic [wsfd_pkg::HcntW-1:0]    hdr_cnt = '0;
	logic [wsfd_pkg::LcodeW-1:0]   len_code = '0;
	logic [63:0]                   len_acc = '0;
	logic [wsfd_pkg::LenW-1:0]     remaining = '0;
	logic [wsfd_pkg::OpcW-1:0]     frm_opc = '0;
	logic                          frm_fin = 1'b0;
	logic                          frm_mask = 1'b0;

	deframe_word_t     pending_words[$];
	deframe_word_t     want;
	int                fails = 0;
	int                burst_left = 0;
	int                stall_cycles = 0;

	websocket_frame_deframer_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.opcode         (opcode),
		.fin_bit        (fin_bit),
		.mask_bit       (mask_bit),
		.payload_length (payload_length),
		.data_byte      (data_byte),
		.last           (last)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic logic [wsfd_pkg::LenW-1:0] clamp_len();
		return (len_acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len_acc[wsfd_pkg::LenW-1:0];
	endfunction

	function automatic deframe_word_t make_word(input logic k,
			input logic [wsfd_pkg::ByteW-1:0] d, input logic lst);
		deframe_word_t w;
		w.kind           = k;
		w.opcode         = frm_opc;
		w.fin_bit        = frm_fin;
		w.mask_bit       = frm_mask;
		w.payload_length = clamp_len();
		w.data_byte      = d;
		w.last           = lst;
		return w;
	endfunction

	// Advances the parser by one byte; made says whether the byte yields a word.
	task automatic parse_byte(input logic [wsfd_pkg::ByteW-1:0] b, output bit made,
			output deframe_word_t w);
		bit                          length_done;
		bit                          header_done;
		logic [wsfd_pkg::HcntW-1:0]  need;
		length_done = 1'b0;
		header_done = 1'b0;
		made = 1'b0;
		w = NO_WORD;
		case (ph)
			PH_SECOND: begin
				frm_mask = b[7];
				len_code = b[6:0];
				hdr_cnt = '0;
				if (len_code == wsfd_pkg::LEN16_CODE || len_code == wsfd_pkg::LEN64_CODE) begin
					len_acc = '0;
					ph = PH_EXTLEN;
				end else begin
					len_acc = {57'd0, len_code};
					length_done = 1'b1;
				end
			end
			PH_EXTLEN: begin
				len_acc = {len_acc[55:0], b};
				hdr_cnt = hdr_cnt + 4'd1;
				need = (len_code == wsfd_pkg::LEN16_CODE) ? wsfd_pkg::LEN16_BYTES
					: wsfd_pkg::LEN64_BYTES;
				if (hdr_cnt >= need)
					length_done = 1'b1;
			end
			PH_KEY: begin
				hdr_cnt = hdr_cnt + 4'd1;
				if (hdr_cnt >= wsfd_pkg::KEY_BYTES)
					header_done = 1'b1;
			end
			PH_DATA: begin
				remaining = remaining - 32'd1;
				made = 1'b1;
				w = make_word(wsfd_pkg::KIND_PAYLOAD, b, remaining == 0);
				if (remaining == 0)
					ph = PH_FIRST;
			end
			default: begin
				frm_fin = b[7];
				frm_opc = b[3:0];
				hdr_cnt = '0;
				len_code = '0;
				len_acc = '0;
				remaining = '0;
				frm_mask = 1'b0;
				ph = PH_SECOND;
			end
		endcase
		if (length_done) begin
			hdr_cnt = '0;
			if (frm_mask)
				ph = PH_KEY;
			else
				header_done = 1'b1;
		end
		if (header_done) begin
			len_acc = {32'd0, clamp_len()};
			remaining = len_acc[wsfd_pkg::LenW-1:0];
			hdr_cnt = '0;
			made = 1'b1;
			w = make_word(wsfd_pkg::KIND_HEADER, 8'h00, remaining == 0);
			ph = (remaining == 0) ? PH_FIRST : PH_DATA;
		end
	endtask

	// Offers one byte, in bursts with random gaps, and returns once it has been taken.
	task automatic send_byte(input logic [wsfd_pkg::ByteW-1:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
			burst_left = $urandom_range(1, 30);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
				rx_byte <= 8'($urandom);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic feed_byte(input logic [wsfd_pkg::ByteW-1:0] b);
		bit            made;
		deframe_word_t w;
		send_byte(b);
		parse_byte(b, made, w);
		if (made)
			pending_words.push_back(w);
	endtask

	task automatic play_row(input int i);
		bit            made;
		deframe_word_t w;
		send_byte(dir_rows[i].rx);
		parse_byte(dir_rows[i].rx, made, w);
		if (dir_rows[i].typed) begin
			if (dir_rows[i].has_word)
				pending_words.push_back(dir_rows[i].w);
		end else if (made) begin
			pending_words.push_back(w);
		end
	endtask

	task automatic drain_words();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	function automatic void cmp_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0h, actual %0h", name, want_v, got_v);
			fails++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				$error("unexpected word: kind %0h data %0h", kind, data_byte);
				fails++;
			end else begin
				want = pending_words.pop_front();
				cmp_field("kind", 32'(want.kind), 32'(kind));
				cmp_field("opcode", 32'(want.opcode), 32'(opcode));
				cmp_field("fin_bit", 32'(want.fin_bit), 32'(fin_bit));
				cmp_field("mask_bit", 32'(want.mask_bit), 32'(mask_bit));
				cmp_field("payload_length", want.payload_length, payload_length);
				cmp_field("data_byte", 32'(want.data_byte), 32'(data_byte));
				cmp_field("last", 32'(want.last), 32'(last));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("websocket_frame_deframer_core test failed");
			$finish;
		end
	end

	// Receiver: segments of random stalling, a full-rate stretch, and a long hold-off that
	// lets the core fill up while bytes keep coming.
	initial begin
		int seg;
		int span;
		int pct;
		seg = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			seg++;
			if (seg % 6 == 2) begin
				span = 80;
				pct = 0;
			end else if (seg % 6 == 0) begin
				span = 30;
				pct = 100;
			end else begin
				span = $urandom_range(10, 40);
				pct = $urandom_range(30, 90);
			end
			repeat (span) begin
				@(negedge clk);
				out_ready <= ($urandom_range(0, 99) < pct);
			end
		end
	end

	initial begin
		int                          sent;
		int                          form;
		int                          k;
		bit                          paused;
		logic                        masked;
		logic [31:0]                 len;
		logic [63:0]                 len64;
		logic [wsfd_pkg::ByteW-1:0]  frame_q[$];
		sent = 0;
		paused = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < TAIL_START; i++)
			play_row(i);
		drain_words();

		// Random well-formed frames: random flags, opcode, key and payload, mostly short.
		while (sent < RAND_ITEMS) begin
			frame_q.delete();
			masked = 1'($urandom_range(0, 1));
			frame_q.push_back({1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
				4'($urandom_range(0, 15))});
			form = $urandom_range(0, 9);
			if (form < 6) begin
				len = (form == 5) ? $urandom_range(0, 125) : $urandom_range(0, 12);
				frame_q.push_back({masked, len[6:0]});
			end else if (form < 8) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(126, 300)
					: $urandom_range(0, 20);
				frame_q.push_back({masked, wsfd_pkg::LEN16_CODE});
				frame_q.push_back(len[15:8]);
				frame_q.push_back(len[7:0]);
			end else begin
				len = $urandom_range(0, 20);
				len64 = {32'd0, len};
				frame_q.push_back({masked, wsfd_pkg::LEN64_CODE});
				for (k = 7; k >= 0; k--)
					frame_q.push_back(len64[8*k +: 8]);
			end
			if (masked)
				repeat (4) frame_q.push_back(8'($urandom));
			repeat (len) frame_q.push_back(8'($urandom));
			foreach (frame_q[j]) begin
				feed_byte(frame_q[j]);
				sent++;
			end
			if (!paused && sent >= RAND_ITEMS / 2) begin
				paused = 1'b1;
				drain_words();
			end
		end

		for (int i = TAIL_START; i < N_ROWS; i++)
			play_row(i);
		drain_words();
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("websocket_frame_deframer_core test passed");
		else
			$display("websocket_frame_deframer_core test failed");
		$finish;
	end

endmodule

// ----- websocket_frame_deframer_core.f -----
hdl/wsfd_pkg.sv
hdl/websocket_frame_deframer_core.sv
test/websocket_frame_deframer_core_tb.sv
